[hdl/sfr_pkg.sv]
// ----------------------------------------------------------------------------
// sfr_pkg
// Types, codes and the CRC-CCITT byte update for the stuffed frame receiver.
// ----------------------------------------------------------------------------
package sfr_pkg;

   localparam logic [7:0]  SYNC_CHAR = 8'h31;
   localparam logic [7:0]  ESC_CHAR  = 8'h30;
   localparam logic [15:0] CRC_INIT  = 16'hFFFF;
   localparam logic [15:0] CRC_POLY  = 16'h8408;

   typedef enum logic [2:0] {
      PH_SYNC1 = 3'd0,
      PH_SYNC2 = 3'd1,
      PH_LEN   = 3'd2,
      PH_DATA  = 3'd3,
      PH_CRCLO = 3'd4,
      PH_CRCHI = 3'd5
   } phase_type;

   typedef enum logic [1:0] {
      KIND_DATA   = 2'd0,
      KIND_OK     = 2'd1,
      KIND_BADCRC = 2'd2,
      KIND_ABORT  = 2'd3
   } kind_type;

   typedef struct packed {
      logic       valid;
      kind_type   kind;
      logic [7:0] payload_byte;
   } result_type;

   // reflected CRC-CCITT, one byte
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] acc;
      acc = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         if (acc[0]) begin
            acc = (acc >> 1) ^ CRC_POLY;
         end else begin
            acc = acc >> 1;
         end
      end
      return acc;
   endfunction

endpackage

[hdl/sfr_parser.sv]
// ----------------------------------------------------------------------------
// sfr_parser
// Frame state machine: sync hunt, unstuffing, length, payload, CRC check.
// ----------------------------------------------------------------------------
module sfr_parser (
   input  logic               clock,
   input  logic               reset,
   input  logic               step_en,
   input  logic [7:0]         rx_byte,
   output sfr_pkg::result_type result
);
   import sfr_pkg::*;

   phase_type   phase_ff,      phase_in;
   logic        esc_ff,        esc_in;
   logic [7:0]  frame_size_ff, frame_size_in;
   logic [8:0]  byte_count_ff, byte_count_in;
   logic [15:0] crc_ff,        crc_in;
   logic [7:0]  crc_low_ff,    crc_low_in;

   logic        in_frame;
   logic        bad_escape;
   logic        escape_start;
   logic [7:0]  data_byte;
   logic [8:0]  count_next;
   logic [15:0] crc_next;
   logic [15:0] crc_got;

   // unstuffing decode
   always_comb begin
      in_frame     = (phase_ff == PH_LEN) || (phase_ff == PH_DATA) ||
                     (phase_ff == PH_CRCLO) || (phase_ff == PH_CRCHI);
      bad_escape   = in_frame && esc_ff && (rx_byte != ESC_CHAR);
      escape_start = in_frame && !esc_ff && (rx_byte == SYNC_CHAR);
      data_byte    = esc_ff ? SYNC_CHAR : rx_byte;
      count_next   = byte_count_ff + 9'd1;
      crc_next     = crc_byte(crc_ff, data_byte);
      crc_got      = {data_byte, crc_low_ff};
   end

   // next state
   always_comb begin
      phase_in      = phase_ff;
      esc_in        = esc_ff;
      frame_size_in = frame_size_ff;
      byte_count_in = byte_count_ff;
      crc_in        = crc_ff;
      crc_low_in    = crc_low_ff;
      if (!in_frame) begin
         esc_in = 1'b0;
         if (phase_ff == PH_SYNC2) begin
            phase_in      = (rx_byte == SYNC_CHAR) ? PH_LEN : PH_SYNC1;
            crc_in        = CRC_INIT;
            byte_count_in = '0;
         end else begin
            phase_in = (rx_byte == SYNC_CHAR) ? PH_SYNC2 : PH_SYNC1;
         end
      end else if (bad_escape) begin
         esc_in   = 1'b0;
         phase_in = PH_SYNC1;
      end else if (escape_start) begin
         esc_in = 1'b1;
      end else begin
         esc_in = 1'b0;
         case (phase_ff)
            PH_LEN: begin
               frame_size_in = data_byte;
               byte_count_in = '0;
               crc_in        = CRC_INIT;
               phase_in      = (data_byte == 8'd0) ? PH_CRCLO : PH_DATA;
            end
            PH_DATA: begin
               crc_in        = crc_next;
               byte_count_in = count_next;
               if (count_next >= {1'b0, frame_size_ff}) begin
                  phase_in = PH_CRCLO;
               end
            end
            PH_CRCLO: begin
               crc_low_in = data_byte;
               phase_in   = PH_CRCHI;
            end
            default: begin
               phase_in = PH_SYNC1;
            end
         endcase
      end
   end

   // result
   always_comb begin
      result.valid        = 1'b0;
      result.kind         = KIND_DATA;
      result.payload_byte = 8'd0;
      if (bad_escape) begin
         result.valid = 1'b1;
         result.kind  = KIND_ABORT;
      end else if (in_frame && !escape_start) begin
         case (phase_ff)
            PH_DATA: begin
               result.valid        = 1'b1;
               result.kind         = KIND_DATA;
               result.payload_byte = data_byte;
            end
            PH_CRCHI: begin
               result.valid = 1'b1;
               result.kind  = (crc_got == crc_ff) ? KIND_OK : KIND_BADCRC;
            end
            default: begin
               result.valid = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_SYNC1;
         esc_ff        <= 1'b0;
         frame_size_ff <= 8'd0;
         byte_count_ff <= 9'd0;
         crc_ff        <= CRC_INIT;
         crc_low_ff    <= 8'd0;
      end else if (step_en) begin
         phase_ff      <= phase_in;
         esc_ff        <= esc_in;
         frame_size_ff <= frame_size_in;
         byte_count_ff <= byte_count_in;
         crc_ff        <= crc_in;
         crc_low_ff    <= crc_low_in;
      end
   end

endmodule

[hdl/stuffed_frame_receiver_crc16.sv]
// ----------------------------------------------------------------------------
// stuffed_frame_receiver_crc16
// Byte-stuffed frame receiver with reflected CRC-CCITT check.
// ----------------------------------------------------------------------------
// Throughput: one input word per cycle while the result channel does not stall;
//   the input register, frame state machine and result register form a two-stage
//   pipeline, and the result of an accepted input word is held in the result register.
// A stall on the result channel holds the pipe once the result register is full.
// Synchronous reset empties both registers and returns to sync hunt.
module stuffed_frame_receiver_crc16 (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [7:0]          req_rx_byte,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [1:0]          rsp_kind,
   output logic [7:0]          rsp_payload_byte
);
   import sfr_pkg::*;

   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       rsp_valid_ff;
   logic [1:0] rsp_kind_ff;
   logic [7:0] rsp_payload_ff;
   logic       advance;
   result_type result;

   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;

   sfr_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .rx_byte (in_byte_ff),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_valid && !req_stall) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= result.valid;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && result.valid) begin
         rsp_kind_ff    <= result.kind;
         rsp_payload_ff <= result.payload_byte;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = rsp_kind_ff;
   assign rsp_payload_byte = rsp_payload_ff;

endmodule

[hdl/sfr_checker.sv]
// ----------------------------------------------------------------------------
// sfr_checker
// Port-level checks for the stuffed frame receiver, bound to the top level.
// ----------------------------------------------------------------------------
module sfr_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [1:0] rsp_kind,
   input logic [7:0] rsp_payload_byte
);
   import sfr_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_payload_byte))
      else $error("stalled response word changed");

   a_status_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind != KIND_DATA) |-> rsp_payload_byte == 8'd0)
      else $error("status word carries nonzero payload");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall, 2))
      else $error("response word without an accepted input word two cycles earlier");

endmodule

bind stuffed_frame_receiver_crc16 sfr_checker u_sfr_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_kind         (rsp_kind),
   .rsp_payload_byte (rsp_payload_byte)
);

[bench/stuffed_frame_receiver_crc16_test.sv]
// ----------------------------------------------------------------------------
// stuffed_frame_receiver_crc16_test
// Drives byte-stuffed frames (good, corrupted CRC, broken escapes) mixed with
// line noise into the receiver and checks every payload word and frame status
// against a cycle-free model of the framing and CRC-CCITT logic.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stuffed_frame_receiver_crc16_test;
   import sfr_pkg::*;

   localparam int WORD_TARGET = 1600;
   localparam int QUIET_LIMIT = 4000;
   localparam int DRAIN_CYCLES = 10;

   typedef enum {FRAME_GOOD, FRAME_BAD_CRC, FRAME_ABORT} frame_style_type;
   typedef enum {STALL_NONE, STALL_COIN, STALL_MASK, STALL_HEAVY} stall_style_type;

   class frame_tracker;
      typedef struct {
         kind_type   kind;
         logic [7:0] data;
      } word_due_type;

      phase_type    phase;
      logic         esc_seen;
      logic [7:0]   size;
      logic [8:0]   count;
      logic [15:0]  crc;
      logic [7:0]   crc_lo;
      word_due_type due_words[$];
      int           errors;
      int           data_words;
      int           ok_frames;
      int           bad_frames;
      int           aborted;

      function new();
         phase = PH_SYNC1;
         esc_seen = 1'b0;
         size = 8'h00;
         count = 9'h000;
         crc = CRC_INIT;
         crc_lo = 8'h00;
      endfunction

      static function logic [15:0] crc_update(logic [15:0] c, logic [7:0] b);
         logic [15:0] acc;
         acc = c ^ {8'h00, b};
         repeat (8) acc = acc[0] ? ((acc >> 1) ^ CRC_POLY) : (acc >> 1);
         return acc;
      endfunction

      function int pending();
         return due_words.size();
      endfunction

      function void report_mismatch(string what);
         $display("MISMATCH: %s", what);
         errors++;
      endfunction

      function void note_word(logic [7:0] raw);
         logic [7:0] b;
         b = raw;
         if (phase == PH_SYNC2) begin
            phase = (b == SYNC_CHAR) ? PH_LEN : PH_SYNC1;
            esc_seen = 1'b0;
            crc = CRC_INIT;
            count = 9'h000;
            return;
         end
         if (phase != PH_LEN && phase != PH_DATA && phase != PH_CRCLO && phase != PH_CRCHI) begin
            phase = (b == SYNC_CHAR) ? PH_SYNC2 : PH_SYNC1;
            esc_seen = 1'b0;
            return;
         end
         if (esc_seen) begin
            esc_seen = 1'b0;
            if (b != ESC_CHAR) begin
               phase = PH_SYNC1;
               due_words.push_back('{KIND_ABORT, 8'h00});
               return;
            end
            b = SYNC_CHAR;
         end else if (b == SYNC_CHAR) begin
            esc_seen = 1'b1;
            return;
         end
         case (phase)
            PH_LEN: begin
               size = b;
               count = 9'h000;
               crc = CRC_INIT;
               phase = (b == 8'h00) ? PH_CRCLO : PH_DATA;
            end
            PH_DATA: begin
               crc = crc_update(crc, b);
               count = count + 9'h001;
               if (count >= {1'b0, size}) phase = PH_CRCLO;
               due_words.push_back('{KIND_DATA, b});
            end
            PH_CRCLO: begin
               crc_lo = b;
               phase = PH_CRCHI;
            end
            default: begin
               phase = PH_SYNC1;
               esc_seen = 1'b0;
               if ({b, crc_lo} == crc) due_words.push_back('{KIND_OK, 8'h00});
               else due_words.push_back('{KIND_BADCRC, 8'h00});
            end
         endcase
      endfunction

      function void check_word(logic [1:0] kind, logic [7:0] data);
         word_due_type w;
         if (due_words.size() == 0) begin
            report_mismatch($sformatf("unexpected word kind %0d byte %02h", kind, data));
            return;
         end
         w = due_words.pop_front();
         if (kind !== w.kind)
            report_mismatch($sformatf("kind %0d, wanted %0d", kind, w.kind));
         if (data !== w.data)
            report_mismatch($sformatf("payload byte %02h, wanted %02h", data, w.data));
         case (w.kind)
            KIND_DATA:   data_words++;
            KIND_OK:     ok_frames++;
            KIND_BADCRC: bad_frames++;
            default:     aborted++;
         endcase
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_rx_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [1:0] rsp_kind;
   logic [7:0] rsp_payload_byte;

   frame_tracker    tracker = new();
   int              words_sent = 0;
   int              burst_left = 0;
   bit              gaps_on = 1'b1;
   int              quiet_cycles = 0;
   stall_style_type stall_mode = STALL_NONE;
   int              stall_span = 0;
   int              stall_step = 0;
   logic [7:0]      stall_mask = 8'h00;

   stuffed_frame_receiver_crc16 i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_payload_byte (rsp_payload_byte)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) tracker.note_word(req_rx_byte);
         if (rsp_valid && !rsp_stall) tracker.check_word(rsp_kind, rsp_payload_byte);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("stuffed_frame_receiver_crc16 regression: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // receiver backpressure
   always @(negedge clock) begin
      if (!reset) begin
         if (stall_span == 0) begin
            stall_mode = stall_style_type'($urandom_range(0, 3));
            stall_span = $urandom_range(40, 300);
            stall_mask = 8'($urandom);
         end
         stall_span--;
         stall_step++;
         case (stall_mode)
            STALL_NONE:  rsp_stall = 1'b0;
            STALL_COIN:  rsp_stall = 1'($urandom_range(0, 1));
            STALL_MASK:  rsp_stall = stall_mask[stall_step % 8];
            default:     rsp_stall = ($urandom_range(0, 9) < 8);
         endcase
      end
   end

   function automatic logic [7:0] random_byte();
      case ($urandom_range(0, 9))
         0:       return SYNC_CHAR;
         1:       return ESC_CHAR;
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic send_word(input logic [7:0] b);
      if (burst_left == 0) begin
         repeat (gaps_on ? $urandom_range(0, 6) : 0) begin
            @(negedge clock);
            req_valid = 1'b0;
         end
         burst_left = $urandom_range(1, 24);
      end
      @(negedge clock);
      req_valid = 1'b1;
      req_rx_byte = b;
      do @(posedge clock); while (req_stall);
      burst_left--;
      words_sent++;
   endtask

   task automatic hold_until_drained();
      @(negedge clock);
      req_valid = 1'b0;
      burst_left = 0;
      while (tracker.pending() != 0) @(posedge clock);
   endtask

   // sync pair, stuffed length/payload/crc; an abort cuts in at a random field
   task automatic send_frame(input logic [7:0] body[$], input frame_style_type style);
      logic [7:0]  fields[$];
      logic [15:0] crc;
      logic [7:0]  offender;
      int          cut;
      crc = CRC_INIT;
      foreach (body[i]) crc = frame_tracker::crc_update(crc, body[i]);
      if (style == FRAME_BAD_CRC) crc ^= 16'h0001 << $urandom_range(0, 15);
      fields.push_back(8'(body.size()));
      foreach (body[i]) fields.push_back(body[i]);
      fields.push_back(crc[7:0]);
      fields.push_back(crc[15:8]);
      cut = (style == FRAME_ABORT) ? $urandom_range(0, fields.size() - 1) : -1;
      send_word(SYNC_CHAR);
      send_word(SYNC_CHAR);
      foreach (fields[i]) begin
         if (i == cut) begin
            do offender = random_byte(); while (offender == ESC_CHAR);
            send_word(SYNC_CHAR);
            send_word(offender);
            return;
         end
         send_word(fields[i]);
         if (fields[i] == SYNC_CHAR) send_word(ESC_CHAR);
      end
   endtask

   initial begin
      logic [7:0]      body[$];
      logic [7:0]      none[$];
      int              frames;
      int              pick;
      int              len;
      frame_style_type style;

      repeat (10) @(negedge clock);
      reset = 1'b0;

      // directed: bad second sync, empty frame, stuffed payload, abort on sync,
      // empty frame with corrupted crc
      send_word(SYNC_CHAR);
      send_word(8'hAA);
      send_frame(none, FRAME_GOOD);
      body = '{SYNC_CHAR, 8'h00, 8'hFF};
      send_frame(body, FRAME_GOOD);
      repeat (4) send_word(SYNC_CHAR);
      send_frame(none, FRAME_BAD_CRC);
      hold_until_drained();

      frames = 0;
      while (words_sent < WORD_TARGET) begin
         gaps_on = ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(1, 6)) send_word(random_byte());
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 72) len = $urandom_range(0, 12);
            else if (pick < 88) len = $urandom_range(13, 40);
            else if (pick < 93) len = SYNC_CHAR;
            else if (pick < 98) len = 0;
            else len = $urandom_range(0, 1) ? 255 : $urandom_range(200, 254);
            body.delete();
            repeat (len) body.push_back(random_byte());
            pick = $urandom_range(0, 99);
            style = (pick < 75) ? FRAME_GOOD : (pick < 87) ? FRAME_BAD_CRC : FRAME_ABORT;
            send_frame(body, style);
            frames++;
            if (frames % 25 == 0) hold_until_drained();
         end
      end

      hold_until_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d input words over %0d random frames plus noise", words_sent, frames);
      $display("checked %0d payload words, %0d good frames, %0d crc errors, %0d aborts",
               tracker.data_words, tracker.ok_frames, tracker.bad_frames, tracker.aborted);
      if (tracker.errors == 0 && tracker.pending() == 0) begin
         $display("stuffed_frame_receiver_crc16 regression: pass");
      end else begin
         $display("stuffed_frame_receiver_crc16 regression: fail");
      end
      $finish;
   end

endmodule

[files.f]
hdl/sfr_pkg.sv
hdl/sfr_parser.sv
hdl/stuffed_frame_receiver_crc16.sv
hdl/sfr_checker.sv
bench/stuffed_frame_receiver_crc16_test.sv
